FILE: rtl/tmda_pkg.sv
// Shared types, widths and constants of the tetrahedron minimum dihedral angle block.
// Depends on nothing; imported by tmda_pair and tet_min_dihedral_angle.
package tmda_pkg;

    localparam int COORD_BITS      = 24;
    localparam int ANGLE_FRAC_BITS = 8;
    localparam int NORM_BITS       = 30;
    localparam int ZFRAC           = 30;
    localparam int CORDIC_ITERS    = 32;
    localparam int SQRT_ITERS      = 32;
    localparam int PRESCALE        = 24;

    // Face normal datapath widths.
    localparam int D_W       = COORD_BITS + 1;   // edge vector component
    localparam int P_W       = 2 * D_W;          // one cross product term
    localparam int NR_W      = P_W + 1;          // exact normal component
    localparam int MAG_W     = NR_W - 2;         // normal magnitude
    localparam int LEN_W     = 7;                // bit length result
    localparam int DET_SPLIT = 26;               // low slice of the determinant multiply
    localparam int PL_W      = DET_SPLIT + 1 + D_W;
    localparam int PH_W      = NR_W - DET_SPLIT + D_W;
    localparam int DET_W     = PH_W + 2 + DET_SPLIT + 1;
    localparam int NM_W      = NORM_BITS + 1;    // rescaled normal component

    // Pair angle datapath widths.
    localparam int PP_W  = 2 * NM_W;             // product of two normal components
    localparam int DOT_W = PP_W + 2;
    localparam int CR_W  = PP_W + 1;
    localparam int PM_W  = PP_W;                 // magnitude after dot and cross
    localparam int SH_W  = 6;
    localparam int SQ1_W = 2 * NORM_BITS;
    localparam int SQ_W  = SQ1_W + 2;
    localparam int RT_W  = SQ_W + 1;
    localparam int CX_W  = 60;
    localparam int Z_W   = 40;

    localparam int PAIR_LAT = 7 + SQRT_ITERS + 1 + CORDIC_ITERS;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic signed [D_W-1:0]        diff_t;
    typedef logic signed [NM_W-1:0]       norm_t;
    typedef logic signed [Z_W-1:0]        zang_t;

    localparam logic signed [63:0] K_DEG   = 64'sd61520874802;
    localparam zang_t              ANG_90  = Z_W'(64'sd90 <<< ZFRAC);
    localparam zang_t              ANG_180 = Z_W'(64'sd180 <<< ZFRAC);

    // Number of bits needed to hold v; zero for zero.
    function automatic logic [LEN_W-1:0] bit_len64(input logic [63:0] v);
        logic [LEN_W-1:0] n;
        n = '0;
        for (int k = 0; k < 64; k++) begin
            if (v[k]) begin
                n = LEN_W'(k + 1);
            end
        end
        return n;
    endfunction

    // CORDIC rotation angle for step i in 2^-30 degree.
    function automatic zang_t atan_step(input int i);
        logic signed [63:0] t;
        unique case (i)
            0:       t = 64'sd48318382080;
            1:       t = 64'sd28524006506;
            2:       t = 64'sd15071301663;
            3:       t = 64'sd7650428050;
            4:       t = 64'sd3840059795;
            5:       t = 64'sd1921901881;
            6:       t = 64'sd961185452;
            7:       t = 64'sd480622056;
            8:       t = 64'sd240314695;
            9:       t = 64'sd120157806;
            10:      t = 64'sd60078960;
            11:      t = 64'sd30039487;
            12:      t = 64'sd15019744;
            13:      t = 64'sd7509872;
            14:      t = 64'sd3754936;
            15:      t = 64'sd1877468;
            default: t = (K_DEG + (64'sd1 <<< (i - 1))) >>> i;
        endcase
        return t[Z_W-1:0];
    endfunction

endpackage

FILE: rtl/tet_min_dihedral_angle.sv
// Top level: minimum dihedral angle of one tetrahedron, fully pipelined.
// Depends on tmda_pkg and tmda_pair.
//
//   Channel  | Ports                              | Word
//   ---------+------------------------------------+---------------------------------------
//   input    | s_valid s_ready s_x0 .. s_z3       | four vertices, 24-bit signed each axis
//   result   | m_valid m_ready m_min_angle        | minimum angle, 1/256 degree, unsigned
//
// One word enters per clock while the output is not stalled.
// The depth is set by the 32-step square root and the 32-step CORDIC in each pair lane.
// Reset clears only the valid bits; the datapath registers are left as they are.
// A stalled output freezes the whole pipeline; the input stage still takes a word
// whenever it is empty, so one word is absorbed while a result waits.
module tet_min_dihedral_angle
    import tmda_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  coord_t      s_x0,
    input  coord_t      s_y0,
    input  coord_t      s_z0,
    input  coord_t      s_x1,
    input  coord_t      s_y1,
    input  coord_t      s_z1,
    input  coord_t      s_x2,
    input  coord_t      s_y2,
    input  coord_t      s_z2,
    input  coord_t      s_x3,
    input  coord_t      s_y3,
    input  coord_t      s_z3,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_min_angle
);

    // Valid bits: input stage, seven normal stages, the pair lanes, three min stages.
    localparam int VLD_N = 8 + PAIR_LAT + 3;
    localparam int RSH   = ZFRAC - ANGLE_FRAC_BITS;
    localparam zang_t RND_HALF = Z_W'(64'sd1 <<< (RSH - 1));
    localparam zang_t ANG_LIM  = Z_W'(64'sd180 <<< ANGLE_FRAC_BITS);
    localparam zang_t OUT_MAX  = Z_W'(64'sd65535);

    // Each edge pair uses the two faces that hold both of its endpoints.
    localparam int PFA [6] = '{2, 1, 1, 0, 0, 0};
    localparam int PFB [6] = '{3, 3, 2, 3, 2, 1};

    logic adv;
    logic vld_reg [VLD_N];
    logic m_valid_reg;

    // Stage 0: captured vertices.
    coord_t p_reg [4][3];

    // Stage 1: edge vectors of each face and the vector from vertex 0 to vertex 3.
    diff_t  eu_next [4][3];
    diff_t  eu_reg  [4][3];
    diff_t  ev_next [4][3];
    diff_t  ev_reg  [4][3];
    diff_t  dd_next [3];
    diff_t  dd1_reg [3];
    diff_t  dd2_reg [3];
    diff_t  dd3_reg [3];

    // Stage 2: cross product terms. Stage 3: exact normals.
    logic signed [P_W-1:0]  prd_next  [4][6];
    logic signed [P_W-1:0]  prd_reg   [4][6];
    logic signed [NR_W-1:0] nraw_next [4][3];
    logic signed [NR_W-1:0] nraw_reg  [4][3];

    // Stage 4: normal magnitudes and the split determinant products.
    logic [MAG_W-1:0]       mag_next [4][3];
    logic [MAG_W-1:0]       mag_reg  [4][3];
    logic                   neg_reg  [4][3];
    logic signed [PL_W-1:0] pl_next  [3];
    logic signed [PL_W-1:0] pl_reg   [3];
    logic signed [PH_W-1:0] ph_next  [3];
    logic signed [PH_W-1:0] ph_reg   [3];

    // Stage 5: determinant partial sums and normal bit lengths.
    logic signed [PL_W+1:0] sl_next, sl_reg;
    logic signed [PH_W+1:0] sh_next, sh_reg;
    logic [LEN_W-1:0]       len_next [4];
    logic [LEN_W-1:0]       len_reg  [4];
    logic [MAG_W-1:0]       mag5_reg [4][3];
    logic                   neg5_reg [4][3];

    // Stage 6: determinant sign and rescaled normals.
    logic signed [DET_W-1:0] det;
    logic                    dpos_next, dpos_reg;
    logic                    dneg_next, dneg_reg;
    norm_t                   n6_next [4][3];
    norm_t                   n6_reg  [4][3];
    logic                    ok6_reg [4];
    logic [MAG_W-1:0]        sv;
    logic [NORM_BITS-1:0]    mnorm;

    // Stage 7: oriented normals.
    norm_t                   nrm_next [4][3];
    norm_t                   nrm_reg  [4][3];
    logic                    ok7_reg  [4];
    logic                    flip;

    // Pair lanes and the minimum tree.
    logic  pok [6];
    zang_t pz  [6];
    zang_t cand [6];
    zang_t m1_next [3];
    zang_t m1_reg  [3];
    zang_t m2_next [2];
    zang_t m2_reg  [2];
    zang_t best_next, best_reg;
    zang_t rnd;
    logic [15:0] ang_next, ang_reg;

    // The pipeline moves whenever the output register is free or being taken.
    assign adv     = !m_valid_reg || m_ready;
    assign s_ready = adv || !vld_reg[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < VLD_N; k++) begin
                vld_reg[k] <= 1'b0;
            end
            m_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                vld_reg[0] <= s_valid;
            end
            if (adv) begin
                for (int k = 1; k < VLD_N; k++) begin
                    vld_reg[k] <= vld_reg[k-1];
                end
                m_valid_reg <= vld_reg[VLD_N-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready) begin
            p_reg[0][0] <= s_x0;
            p_reg[0][1] <= s_y0;
            p_reg[0][2] <= s_z0;
            p_reg[1][0] <= s_x1;
            p_reg[1][1] <= s_y1;
            p_reg[1][2] <= s_z1;
            p_reg[2][0] <= s_x2;
            p_reg[2][1] <= s_y2;
            p_reg[2][2] <= s_z2;
            p_reg[3][0] <= s_x3;
            p_reg[3][1] <= s_y3;
            p_reg[3][2] <= s_z3;
        end
    end

    always_comb begin
        // Face e is spanned by vertices e+1, e+2 and e+3, taken modulo four.
        for (int e = 0; e < 4; e++) begin
            for (int k = 0; k < 3; k++) begin
                eu_next[e][k] = D_W'(p_reg[(e + 2) % 4][k]) - D_W'(p_reg[(e + 1) % 4][k]);
                ev_next[e][k] = D_W'(p_reg[(e + 3) % 4][k]) - D_W'(p_reg[(e + 1) % 4][k]);
            end
        end
        for (int k = 0; k < 3; k++) begin
            dd_next[k] = D_W'(p_reg[3][k]) - D_W'(p_reg[0][k]);
        end

        for (int e = 0; e < 4; e++) begin
            prd_next[e][0] = eu_reg[e][1] * ev_reg[e][2];
            prd_next[e][1] = eu_reg[e][2] * ev_reg[e][1];
            prd_next[e][2] = eu_reg[e][2] * ev_reg[e][0];
            prd_next[e][3] = eu_reg[e][0] * ev_reg[e][2];
            prd_next[e][4] = eu_reg[e][0] * ev_reg[e][1];
            prd_next[e][5] = eu_reg[e][1] * ev_reg[e][0];
            for (int k = 0; k < 3; k++) begin
                nraw_next[e][k] = NR_W'(prd_reg[e][2*k]) - NR_W'(prd_reg[e][2*k+1]);
                mag_next[e][k]  = nraw_reg[e][k][NR_W-1] ? MAG_W'(-nraw_reg[e][k])
                                                         : MAG_W'(nraw_reg[e][k]);
            end
        end

        // The normal of face 3 dotted with the vector from vertex 0 to vertex 3 gives the
        // orientation. Each component is split so that no multiply exceeds about 27 by 25 bits.
        for (int k = 0; k < 3; k++) begin
            pl_next[k] = $signed({1'b0, nraw_reg[3][k][DET_SPLIT-1:0]}) * dd3_reg[k];
            ph_next[k] = $signed(nraw_reg[3][k][NR_W-1:DET_SPLIT]) * dd3_reg[k];
        end
        sl_next = (PL_W+2)'(pl_reg[0]) + (PL_W+2)'(pl_reg[1]) + (PL_W+2)'(pl_reg[2]);
        sh_next = (PH_W+2)'(ph_reg[0]) + (PH_W+2)'(ph_reg[1]) + (PH_W+2)'(ph_reg[2]);
        for (int e = 0; e < 4; e++) begin
            len_next[e] = bit_len64(64'(mag_reg[e][0] | mag_reg[e][1] | mag_reg[e][2]));
        end

        det = (DET_W'(sh_reg) <<< DET_SPLIT) + DET_W'(sl_reg);
        dneg_next = det[DET_W-1];
        dpos_next = !det[DET_W-1] && (det != '0);

        // Scale each normal so that its largest component has exactly NORM_BITS bits.
        for (int e = 0; e < 4; e++) begin
            for (int k = 0; k < 3; k++) begin
                if (len_reg[e] > LEN_W'(NORM_BITS)) begin
                    sv = mag5_reg[e][k] >> (len_reg[e] - LEN_W'(NORM_BITS));
                end else begin
                    sv = mag5_reg[e][k] << (LEN_W'(NORM_BITS) - len_reg[e]);
                end
                mnorm = sv[NORM_BITS-1:0];
                n6_next[e][k] = neg5_reg[e][k] ? -$signed({1'b0, mnorm})
                                               : $signed({1'b0, mnorm});
            end
        end

        // Turn each normal away from its opposite vertex; a flat tetrahedron
        // leaves every normal as it is.
        for (int e = 0; e < 4; e++) begin
            flip = ok6_reg[e] && ((((e % 2) == 1) && dpos_reg) || (((e % 2) == 0) && dneg_reg));
            for (int k = 0; k < 3; k++) begin
                nrm_next[e][k] = flip ? -n6_reg[e][k] : n6_reg[e][k];
            end
        end

        // A pair that touches a degenerate face stands as 180 degrees.
        for (int q = 0; q < 6; q++) begin
            cand[q] = pok[q] ? pz[q] : ANG_180;
        end
        for (int q = 0; q < 3; q++) begin
            m1_next[q] = (cand[2*q+1] < cand[2*q]) ? cand[2*q+1] : cand[2*q];
        end
        m2_next[0] = (m1_reg[1] < m1_reg[0]) ? m1_reg[1] : m1_reg[0];
        m2_next[1] = m1_reg[2];
        best_next  = (m2_reg[1] < m2_reg[0]) ? m2_reg[1] : m2_reg[0];

        // Round half up to the output resolution and clamp to the range 0 to 180 degrees.
        rnd = (best_reg + RND_HALF) >>> RSH;
        if (best_reg < 0) begin
            rnd = '0;
        end
        if (rnd > ANG_LIM) begin
            rnd = ANG_LIM;
        end
        if (rnd > OUT_MAX) begin
            rnd = OUT_MAX;
        end
        ang_next = rnd[15:0];
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            eu_reg   <= eu_next;
            ev_reg   <= ev_next;
            dd1_reg  <= dd_next;
            dd2_reg  <= dd1_reg;
            dd3_reg  <= dd2_reg;
            prd_reg  <= prd_next;
            nraw_reg <= nraw_next;
            mag_reg  <= mag_next;
            for (int e = 0; e < 4; e++) begin
                for (int k = 0; k < 3; k++) begin
                    neg_reg[e][k] <= nraw_reg[e][k][NR_W-1];
                end
            end
            pl_reg   <= pl_next;
            ph_reg   <= ph_next;
            sl_reg   <= sl_next;
            sh_reg   <= sh_next;
            len_reg  <= len_next;
            mag5_reg <= mag_reg;
            neg5_reg <= neg_reg;
            dpos_reg <= dpos_next;
            dneg_reg <= dneg_next;
            n6_reg   <= n6_next;
            for (int e = 0; e < 4; e++) begin
                ok6_reg[e] <= (len_reg[e] != '0);
            end
            nrm_reg  <= nrm_next;
            ok7_reg  <= ok6_reg;
            m1_reg   <= m1_next;
            m2_reg   <= m2_next;
            best_reg <= best_next;
            ang_reg  <= ang_next;
        end
    end

    for (genvar q = 0; q < 6; q++) begin : g_pair
        tmda_pair u_pair (
            .aclk   (aclk),
            .en     (adv),
            .in_ok  (ok7_reg[PFA[q]] && ok7_reg[PFB[q]]),
            .a      (nrm_reg[PFA[q]]),
            .b      (nrm_reg[PFB[q]]),
            .out_ok (pok[q]),
            .out_z  (pz[q])
        );
    end

    assign m_valid     = m_valid_reg;
    assign m_min_angle = ang_reg;

endmodule

FILE: rtl/tmda_pair.sv
// Angle pipeline for one pair of face normals: dot and cross products, square root, CORDIC.
// Depends on tmda_pkg. Instantiated six times by tet_min_dihedral_angle.
module tmda_pair
    import tmda_pkg::*;
(
    input  logic  aclk,
    input  logic  en,
    input  logic  in_ok,
    input  norm_t a [3],
    input  norm_t b [3],
    output logic  out_ok,
    output zang_t out_z
);

    logic                    ok_reg [PAIR_LAT];

    logic signed [PP_W-1:0]  pd_next [3];
    logic signed [PP_W-1:0]  pd_reg  [3];
    logic signed [PP_W-1:0]  pc_next [6];
    logic signed [PP_W-1:0]  pc_reg  [6];

    logic signed [DOT_W-1:0] x_next, x_reg;
    logic signed [CR_W-1:0]  c_next [3];
    logic signed [CR_W-1:0]  c_reg  [3];

    logic [PM_W-1:0]         mx_next, mx_reg;
    logic [PM_W-1:0]         mc_next [3];
    logic [PM_W-1:0]         mc_reg  [3];
    logic                    xn_next, xn_reg;

    logic [LEN_W-1:0]        len4;
    logic [SH_W-1:0]         s_next, s_reg;
    logic [PM_W-1:0]         mx4_reg;
    logic [PM_W-1:0]         mc4_reg [3];
    logic                    xn4_reg;

    logic [NORM_BITS-1:0]    vx_next, vx5_reg;
    logic [NORM_BITS-1:0]    vc_next [3];
    logic [NORM_BITS-1:0]    vc5_reg [3];
    logic                    xn5_reg;

    logic [SQ1_W-1:0]        sq_next [3];
    logic [SQ1_W-1:0]        sq_reg  [3];
    logic [NORM_BITS-1:0]    vx6_reg;
    logic                    xn6_reg;

    // Square root stages; entry zero holds the sum of squares.
    logic [RT_W-1:0]         rem_next  [SQRT_ITERS+1];
    logic [RT_W-1:0]         rem_reg   [SQRT_ITERS+1];
    logic [RT_W-1:0]         root_next [SQRT_ITERS+1];
    logic [RT_W-1:0]         root_reg  [SQRT_ITERS+1];
    logic [NORM_BITS-1:0]    sx_reg    [SQRT_ITERS+1];
    logic                    sn_reg    [SQRT_ITERS+1];

    // CORDIC stages; entry zero holds the prescaled, pre-rotated vector.
    logic signed [CX_W-1:0]  cx_next [CORDIC_ITERS+1];
    logic signed [CX_W-1:0]  cx_reg  [CORDIC_ITERS+1];
    logic signed [CX_W-1:0]  cy_next [CORDIC_ITERS+1];
    logic signed [CX_W-1:0]  cy_reg  [CORDIC_ITERS+1];
    zang_t                   cz_next [CORDIC_ITERS+1];
    zang_t                   cz_reg  [CORDIC_ITERS+1];

    logic signed [CX_W-1:0]  x_pre, y_pre;
    logic [RT_W-1:0]         trial;
    logic [RT_W-1:0]         bitv;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            pd_next[k] = a[k] * b[k];
        end
        pc_next[0] = a[1] * b[2];
        pc_next[1] = a[2] * b[1];
        pc_next[2] = a[2] * b[0];
        pc_next[3] = a[0] * b[2];
        pc_next[4] = a[0] * b[1];
        pc_next[5] = a[1] * b[0];

        x_next = -(DOT_W'(pd_reg[0]) + DOT_W'(pd_reg[1]) + DOT_W'(pd_reg[2]));
        for (int k = 0; k < 3; k++) begin
            c_next[k] = CR_W'(pc_reg[2*k]) - CR_W'(pc_reg[2*k+1]);
        end

        xn_next = x_reg[DOT_W-1];
        mx_next = xn_next ? PM_W'(-x_reg) : PM_W'(x_reg);
        for (int k = 0; k < 3; k++) begin
            mc_next[k] = c_reg[k][CR_W-1] ? PM_W'(-c_reg[k]) : PM_W'(c_reg[k]);
        end

        len4 = bit_len64(64'(mx_reg | mc_reg[0] | mc_reg[1] | mc_reg[2]));
        s_next = (len4 > LEN_W'(NORM_BITS)) ? SH_W'(len4 - LEN_W'(NORM_BITS)) : '0;

        vx_next = NORM_BITS'(mx4_reg >> s_reg);
        for (int k = 0; k < 3; k++) begin
            vc_next[k] = NORM_BITS'(mc4_reg[k] >> s_reg);
            sq_next[k] = SQ1_W'(vc5_reg[k]) * SQ1_W'(vc5_reg[k]);
        end

        rem_next[0]  = RT_W'(sq_reg[0]) + RT_W'(sq_reg[1]) + RT_W'(sq_reg[2]);
        root_next[0] = '0;
        // Restoring square root, one result bit per stage.
        for (int j = 0; j < SQRT_ITERS; j++) begin
            bitv  = RT_W'(1) << (2 * (SQRT_ITERS - 1 - j));
            trial = root_reg[j] + bitv;
            if (rem_reg[j] >= trial) begin
                rem_next[j+1]  = rem_reg[j] - trial;
                root_next[j+1] = (root_reg[j] >> 1) + bitv;
            end else begin
                rem_next[j+1]  = rem_reg[j];
                root_next[j+1] = root_reg[j] >> 1;
            end
        end

        // A negative x starts the vector rotated by 90 degrees.
        x_pre = sn_reg[SQRT_ITERS] ? -$signed(CX_W'(sx_reg[SQRT_ITERS]))
                                   : $signed(CX_W'(sx_reg[SQRT_ITERS]));
        x_pre = x_pre <<< PRESCALE;
        y_pre = $signed(CX_W'(root_reg[SQRT_ITERS])) <<< PRESCALE;
        if (x_pre < 0) begin
            cx_next[0] = y_pre;
            cy_next[0] = -x_pre;
            cz_next[0] = ANG_90;
        end else begin
            cx_next[0] = x_pre;
            cy_next[0] = y_pre;
            cz_next[0] = '0;
        end

        for (int i = 0; i < CORDIC_ITERS; i++) begin
            if (cy_reg[i] > 0) begin
                cx_next[i+1] = cx_reg[i] + (cy_reg[i] >>> i);
                cy_next[i+1] = cy_reg[i] - (cx_reg[i] >>> i);
                cz_next[i+1] = cz_reg[i] + atan_step(i);
            end else begin
                cx_next[i+1] = cx_reg[i] - (cy_reg[i] >>> i);
                cy_next[i+1] = cy_reg[i] + (cx_reg[i] >>> i);
                cz_next[i+1] = cz_reg[i] - atan_step(i);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ok_reg[0] <= in_ok;
            for (int k = 1; k < PAIR_LAT; k++) begin
                ok_reg[k] <= ok_reg[k-1];
            end
            pd_reg  <= pd_next;
            pc_reg  <= pc_next;
            x_reg   <= x_next;
            c_reg   <= c_next;
            mx_reg  <= mx_next;
            mc_reg  <= mc_next;
            xn_reg  <= xn_next;
            s_reg   <= s_next;
            mx4_reg <= mx_reg;
            mc4_reg <= mc_reg;
            xn4_reg <= xn_reg;
            vx5_reg <= vx_next;
            vc5_reg <= vc_next;
            xn5_reg <= xn4_reg;
            sq_reg  <= sq_next;
            vx6_reg <= vx5_reg;
            xn6_reg <= xn5_reg;
            sx_reg[0] <= vx6_reg;
            sn_reg[0] <= xn6_reg;
            for (int j = 1; j <= SQRT_ITERS; j++) begin
                sx_reg[j] <= sx_reg[j-1];
                sn_reg[j] <= sn_reg[j-1];
            end
            rem_reg  <= rem_next;
            root_reg <= root_next;
            cx_reg   <= cx_next;
            cy_reg   <= cy_next;
            cz_reg   <= cz_next;
        end
    end

    assign out_ok = ok_reg[PAIR_LAT-1];
    assign out_z  = cz_reg[CORDIC_ITERS];

endmodule
